// ----- sv/tcgs_pkg.sv -----
// shared constants and types for the text console glyph sequencer
// no dependencies; imported by tcgs_font_store and text_console_glyph_sequencer_unit
package tcgs_pkg;

	localparam int GLYPH_COUNT  = 96;
	localparam int GLYPH_HEIGHT = 16;
	localparam int GLYPH_WIDTH  = 8;

	// font rows are held as row pairs: even rows in one bank, odd rows in the other
	localparam int PAIR_COUNT  = GLYPH_HEIGHT / 2;
	localparam int PAIR_W      = $clog2(PAIR_COUNT);
	localparam int GLYPH_W     = 7;
	localparam int FONT_DEPTH  = GLYPH_COUNT * PAIR_COUNT;
	localparam int FONT_AW     = GLYPH_W + PAIR_W;

	localparam logic [GLYPH_WIDTH-1:0] BOX_EDGE   = 8'h7E;
	localparam logic [GLYPH_WIDTH-1:0] BOX_INSIDE = 8'h42;

	localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
	localparam logic [7:0] LAST_PRINTABLE  = 8'h7F;
	localparam logic [7:0] CHAR_QUERY      = 8'h3F;
	localparam logic [7:0] CHAR_CR         = 8'h0D;
	localparam logic [7:0] CHAR_LF         = 8'h0A;
	localparam logic [7:0] CHAR_TAB        = 8'h09;
	localparam logic [7:0] CHAR_BS         = 8'h08;

	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_FONT   = 2'd1;
	localparam logic [1:0] CMD_CURSOR = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] OP_DRAW   = 2'd0;
	localparam logic [1:0] OP_SCROLL = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic REG_TEXT_COLUMNS = 1'b0;
	localparam logic REG_TEXT_ROWS    = 1'b1;

	typedef struct packed {
		logic                   en;
		logic [FONT_AW-1:0]     addr;
		logic                   odd;
		logic [GLYPH_WIDTH-1:0] data;
	} font_wr_t;

endpackage

// ----- sv/text_console_glyph_sequencer_unit.sv -----
// Character-cell console sequencer. One input transaction is one command; a printable
// character gives eight row-pair results, one per cycle while the output is taken, read from
// the font store one row pair per cycle, so a character passes through accept, decode and
// eight reads, plus a scroll mark when it wraps into a scroll. Font writes, cursor moves,
// CR and LF without a scroll end after decode with no result; a tab takes up to four cells.
// After reset the font store runs a clearing pass over all 768 entries that loads the box
// glyphs, during which no transaction is accepted; configuration writes are taken at any time.
// depends on tcgs_pkg and tcgs_font_store
module text_console_glyph_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// char_code[7:0], font_index[14:8], font_row[18:15], font_data[26:19],
	// cursor_col[34:27], cursor_line[41:35], zero fill
	input  logic [47:0] s_tdata,
	// command[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_col[7:0], cell_line[14:8], row_pair[17:15], glyph_bits[33:18], zero fill
	output logic [39:0] m_tdata,
	// op[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	import tcgs_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_DRAW   = 3'd2;
	localparam logic [2:0] ST_MARK   = 3'd3;

	logic [8:0] text_columns_q;
	logic [7:0] text_rows_q;
	logic [8:0] cols;
	logic [7:0] rows;

	logic [2:0] state_q, state_d;
	logic [7:0] cur_x_q, cur_x_d;
	logic [6:0] cur_y_q, cur_y_d;
	logic [PAIR_W-1:0] pair_q, pair_d;
	logic [GLYPH_W-1:0] glyph_q, glyph_d;
	logic       blank_q, blank_d;
	logic       tab_q, tab_d;
	logic [8:0] stop_q, stop_d;
	logic [1:0] mark_op_q, mark_op_d;

	// captured command
	logic [1:0] cmd_q;
	logic [7:0] char_q;
	logic [6:0] fidx_q;
	logic [3:0] frow_q;
	logic [7:0] fdata_q;
	logic [7:0] ccol_q;
	logic [6:0] cline_q;

	// result stage waiting on the font read, then the output register
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] col_s1;
	logic [6:0] line_s1;
	logic [PAIR_W-1:0] pair_s1;
	logic       blank_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic [1:0] out_op_q;
	logic [7:0] out_col_q;
	logic [6:0] out_line_q;
	logic [PAIR_W-1:0] out_pair_q;
	logic [15:0] out_bits_q;
	logic       out_last_q;

	logic       accept;
	logic       move_s1;
	logic       issue_ok;
	logic       push;
	logic [1:0] p_op;
	logic [7:0] p_col;
	logic [6:0] p_line;
	logic [PAIR_W-1:0] p_pair;
	logic       p_blank;
	logic       p_last;

	logic [8:0] x_inc;
	logic [7:0] y_inc;
	logic       wrap;
	logic       scroll;
	logic       more;
	logic [7:0] glyph_sub;

	font_wr_t   font_wr;
	logic       font_rd_en;
	logic [15:0] font_rd_data;
	logic       font_ready;

	assign cols = (text_columns_q > 9'd256) ? 9'd256 : text_columns_q;
	assign rows = (text_rows_q > 8'd128) ? 8'd128 : text_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_columns_q <= 9'd80;
			text_rows_q    <= 8'd30;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_COLUMNS: text_columns_q <= cfg_data;
				REG_TEXT_ROWS:    text_rows_q    <= cfg_data[7:0];
				default:          ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE) && font_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tuser;
			char_q  <= s_tdata[7:0];
			fidx_q  <= s_tdata[14:8];
			frow_q  <= s_tdata[18:15];
			fdata_q <= s_tdata[26:19];
			ccol_q  <= s_tdata[34:27];
			cline_q <= s_tdata[41:35];
		end
	end

	assign move_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign issue_ok = !valid_s1 || move_s1;

	assign x_inc  = {1'b0, cur_x_q} + 9'd1;
	assign y_inc  = {1'b0, cur_y_q} + 8'd1;
	assign wrap   = x_inc >= cols;
	assign scroll = wrap && (y_inc >= rows);
	assign more   = tab_q && !wrap && (x_inc < stop_q);
	assign glyph_sub = char_q - FIRST_PRINTABLE;

	always_comb begin
		state_d   = state_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		pair_d    = pair_q;
		glyph_d   = glyph_q;
		blank_d   = blank_q;
		tab_d     = tab_q;
		stop_d    = stop_q;
		mark_op_d = mark_op_q;
		push      = 1'b0;
		p_op      = OP_DRAW;
		p_col     = cur_x_q;
		p_line    = cur_y_q;
		p_pair    = pair_q;
		p_blank   = blank_q;
		p_last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				pair_d  = '0;
				case (cmd_q)
					CMD_PUT: begin
						if (cols != 9'd0 && rows != 8'd0) begin
							case (char_q)
								CHAR_CR: cur_x_d = '0;
								CHAR_LF: begin
									cur_x_d = '0;
									if (y_inc >= rows) begin
										cur_y_d   = 7'(rows - 8'd1);
										mark_op_d = OP_SCROLL;
										state_d   = ST_MARK;
									end else begin
										cur_y_d = y_inc[6:0];
									end
								end
								CHAR_TAB: begin
									glyph_d = '0;
									blank_d = 1'b0;
									tab_d   = 1'b1;
									stop_d  = ({1'b0, cur_x_q} + 9'd4) & ~9'd3;
									state_d = ST_DRAW;
								end
								CHAR_BS: begin
									if (cur_x_q != 8'd0) begin
										cur_x_d = cur_x_q - 8'd1;
										blank_d = 1'b1;
										tab_d   = 1'b0;
										state_d = ST_DRAW;
									end
								end
								default: begin
									if (char_q >= FIRST_PRINTABLE && char_q <= LAST_PRINTABLE) begin
										glyph_d = glyph_sub[GLYPH_W-1:0];
									end else begin
										glyph_d = 7'(CHAR_QUERY - FIRST_PRINTABLE);
									end
									blank_d = 1'b0;
									tab_d   = 1'b0;
									state_d = ST_DRAW;
								end
							endcase
						end
					end
					CMD_FONT: ;
					CMD_CURSOR: begin
						if (cols == 9'd0) begin
							cur_x_d = '0;
						end else if ({1'b0, ccol_q} < cols) begin
							cur_x_d = ccol_q;
						end else begin
							cur_x_d = 8'(cols - 9'd1);
						end
						if (rows == 8'd0) begin
							cur_y_d = '0;
						end else if ({1'b0, cline_q} < rows) begin
							cur_y_d = cline_q;
						end else begin
							cur_y_d = 7'(rows - 8'd1);
						end
					end
					CMD_CLEAR: begin
						mark_op_d = OP_CLEAR;
						state_d   = ST_MARK;
					end
					default: ;
				endcase
			end
			ST_DRAW: begin
				if (issue_ok) begin
					push   = 1'b1;
					pair_d = pair_q + 1'b1;
					if (pair_q == PAIR_W'(PAIR_COUNT - 1)) begin
						p_last  = blank_q || (!scroll && !more);
						state_d = ST_IDLE;
						if (!blank_q) begin
							if (wrap) begin
								cur_x_d = '0;
								if (scroll) begin
									cur_y_d   = 7'(rows - 8'd1);
									mark_op_d = OP_SCROLL;
									state_d   = ST_MARK;
								end else begin
									cur_y_d = y_inc[6:0];
								end
							end else begin
								cur_x_d = x_inc[7:0];
								if (more) begin
									state_d = ST_DRAW;
								end
							end
						end
					end
				end
			end
			ST_MARK: begin
				if (issue_ok) begin
					push    = 1'b1;
					p_op    = mark_op_q;
					p_col   = '0;
					p_line  = '0;
					p_pair  = '0;
					p_blank = 1'b1;
					p_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			pair_q      <= '0;
			blank_q     <= 1'b0;
			tab_q       <= 1'b0;
			mark_op_q   <= OP_CLEAR;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_x_q   <= cur_x_d;
			cur_y_q   <= cur_y_d;
			pair_q    <= pair_d;
			blank_q   <= blank_d;
			tab_q     <= tab_d;
			mark_op_q <= mark_op_d;
			if (push) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		glyph_q <= glyph_d;
		stop_q  <= stop_d;
		if (push) begin
			op_s1    <= p_op;
			col_s1   <= p_col;
			line_s1  <= p_line;
			pair_s1  <= p_pair;
			blank_s1 <= p_blank;
			last_s1  <= p_last;
		end
		if (move_s1) begin
			out_op_q   <= op_s1;
			out_col_q  <= col_s1;
			out_line_q <= line_s1;
			out_pair_q <= pair_s1;
			out_bits_q <= blank_s1 ? 16'd0 : font_rd_data;
			out_last_q <= last_s1;
		end
	end

	// font writes land while decoding; glyphs past the table are dropped
	always_comb begin
		font_wr.en   = (state_q == ST_DECODE) && (cmd_q == CMD_FONT) &&
		               (fidx_q < GLYPH_W'(GLYPH_COUNT));
		font_wr.addr = {fidx_q, frow_q[3:1]};
		font_wr.odd  = frow_q[0];
		font_wr.data = fdata_q;
	end

	// read only on a push, so the read data holds while the result stage stalls
	assign font_rd_en = push && (state_q == ST_DRAW);

	tcgs_font_store u_font (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (font_wr),
		.rd_en   (font_rd_en),
		.rd_addr ({glyph_q, pair_q}),
		.rd_data (font_rd_data),
		.ready   (font_ready)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_op_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_bits_q, out_pair_q, out_line_q, out_col_q};

	a_stall_holds_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move_s1 |=> $stable(font_rd_data))
		else $error("font read data changed under a stalled result");

	a_idle_pending_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && valid_s1 |-> last_s1)
		else $error("pending result in idle is not the final one");

	a_pair_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pair_q == '0))
		else $error("row pair counter not back at zero");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		font_rd_en |-> font_ready)
		else $error("font read during clearing pass");

endmodule

// ----- sv/tcgs_font_store.sv -----
// font store: two banks of glyph rows (even and odd rows), one write and one read port
// reset runs a clearing pass that loads the box pattern; depends on tcgs_pkg
module tcgs_font_store (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  tcgs_pkg::font_wr_t                         wr,
	input  logic                                       rd_en,
	input  logic [tcgs_pkg::FONT_AW-1:0]               rd_addr,
	output logic [2*tcgs_pkg::GLYPH_WIDTH-1:0]         rd_data,
	output logic                                       ready
);
	import tcgs_pkg::*;

	logic [GLYPH_WIDTH-1:0] even_mem [FONT_DEPTH];
	logic [GLYPH_WIDTH-1:0] odd_mem  [FONT_DEPTH];
	logic [FONT_AW-1:0]     clr_addr_q;
	logic                   clr_busy_q;
	logic [2*GLYPH_WIDTH-1:0] rd_data_q;
	logic [PAIR_W-1:0]      clr_pair;
	logic [GLYPH_WIDTH-1:0] clr_even;
	logic [GLYPH_WIDTH-1:0] clr_odd;

	assign clr_pair = clr_addr_q[PAIR_W-1:0];
	// top row lives in the first even entry, bottom row in the last odd entry
	assign clr_even = (clr_pair == '0) ? BOX_EDGE : BOX_INSIDE;
	assign clr_odd  = (clr_pair == PAIR_W'(PAIR_COUNT - 1)) ? BOX_EDGE : BOX_INSIDE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == FONT_AW'(FONT_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			even_mem[clr_addr_q] <= clr_even;
			odd_mem[clr_addr_q]  <= clr_odd;
		end else if (wr.en) begin
			if (wr.odd) begin
				odd_mem[wr.addr] <= wr.data;
			end else begin
				even_mem[wr.addr] <= wr.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= {even_mem[rd_addr], odd_mem[rd_addr]};
		end
	end

	assign rd_data = rd_data_q;
	assign ready   = !clr_busy_q;

endmodule
